FILE: src/epoch_count_to_calendar_core_macros.svh
// Assertion macros for the epoch count to calendar core checker
`ifndef EPOCH_COUNT_TO_CALENDAR_CORE_MACROS_SVH
`define EPOCH_COUNT_TO_CALENDAR_CORE_MACROS_SVH

// check outside reset
`define ECC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define ECC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ecc_pkg.sv
// Types, constants, microcode and tables of the epoch count to calendar core
package ecc_pkg;

  localparam int TIME_W      = 42;
  localparam int SEC_W       = 32;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 48;
  localparam int BASE_W      = 12;
  localparam int REM_W       = 10;
  localparam int DIGIT_W     = REM_W + 2;
  localparam int DAYS_W      = 16;
  localparam int CNT_W       = 5;
  localparam int UPC_W       = 3;

  localparam logic [BASE_W-1:0] BASE_YEAR_RESET = 12'd1970;
  localparam logic [BASE_W-1:0] YEAR_CYCLE      = 12'd400;
  localparam logic [BASE_W-1:0] YEAR_CYCLE_LAST = 12'd399;
  localparam logic [DAYS_W-1:0] DAYS_YEAR       = 16'd365;
  localparam logic [DAYS_W-1:0] DAYS_LEAP       = 16'd366;
  localparam logic [3:0]        MONTHS          = 4'd12;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_IDLE  = 3'd0;
  localparam upc_t UPC_MS    = 3'd1;
  localparam upc_t UPC_SEC   = 3'd2;
  localparam upc_t UPC_MIN   = 3'd3;
  localparam upc_t UPC_HOUR  = 3'd4;
  localparam upc_t UPC_YEAR  = 3'd5;
  localparam upc_t UPC_MONTH = 3'd6;
  localparam upc_t UPC_EMIT  = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DIV,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ACCEPT,
    COND_COUNT,
    COND_YEAR_END,
    COND_MONTH_END,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {
    DIV_1000,
    DIV_60,
    DIV_24
  } div_sel_t;

  typedef enum logic [1:0] {
    DST_MSEC,
    DST_SEC,
    DST_MIN,
    DST_HOUR
  } dst_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    div_sel_t        div;
    logic            wide;
    dst_t            dst;
    logic [CNT_W-1:0] iters;
    upc_t            next;
    upc_t            jump;
  } uword_t;

  typedef struct packed {
    op_t      op;
    div_sel_t div;
    logic     wide;
    dst_t     dst;
    logic     last;
    logic     accept;
  } dp_ctrl_t;

  typedef struct packed {
    logic year_end;
    logic month_end;
  } dp_stat_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] d3;
    logic [DIGIT_W-1:0] d2;
    logic [DIGIT_W-1:0] d1;
  } div_k_t;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '{op: OP_EMIT, cond: COND_OUT_FREE, div: DIV_60, wide: 1'b0, dst: DST_SEC,
          iters: 5'd0, next: UPC_IDLE, jump: UPC_IDLE};
    unique case (pc)
      UPC_IDLE: begin
        w.op = OP_LOAD;  w.cond = COND_ACCEPT;  w.next = UPC_SEC;  w.jump = UPC_MS;
      end
      UPC_MS: begin
        w.op = OP_DIV;  w.cond = COND_COUNT;  w.div = DIV_1000;  w.wide = 1'b1;
        w.dst = DST_MSEC;  w.iters = 5'd21;  w.next = UPC_SEC;
      end
      UPC_SEC: begin
        w.op = OP_DIV;  w.cond = COND_COUNT;  w.div = DIV_60;  w.dst = DST_SEC;
        w.iters = 5'd16;  w.next = UPC_MIN;
      end
      UPC_MIN: begin
        w.op = OP_DIV;  w.cond = COND_COUNT;  w.div = DIV_60;  w.dst = DST_MIN;
        w.iters = 5'd16;  w.next = UPC_HOUR;
      end
      UPC_HOUR: begin
        w.op = OP_DIV;  w.cond = COND_COUNT;  w.div = DIV_24;  w.dst = DST_HOUR;
        w.iters = 5'd16;  w.next = UPC_YEAR;
      end
      UPC_YEAR: begin
        w.op = OP_YEAR;  w.cond = COND_YEAR_END;  w.next = UPC_MONTH;
      end
      UPC_MONTH: begin
        w.op = OP_MONTH;  w.cond = COND_MONTH_END;  w.next = UPC_EMIT;
      end
      UPC_EMIT: begin
        w.op = OP_EMIT;  w.cond = COND_OUT_FREE;  w.next = UPC_IDLE;
      end
      default: begin
        w.op = OP_EMIT;  w.cond = COND_OUT_FREE;  w.next = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic div_k_t div_consts(div_sel_t sel);
    div_k_t k;
    unique case (sel)
      DIV_1000: k = '{d3: 12'd3000, d2: 12'd2000, d1: 12'd1000};
      DIV_60:   k = '{d3: 12'd180,  d2: 12'd120,  d1: 12'd60};
      DIV_24:   k = '{d3: 12'd72,   d2: 12'd48,   d1: 12'd24};
      default:  k = '{d3: 12'd180,  d2: 12'd120,  d1: 12'd60};
    endcase
    return k;
  endfunction

  function automatic logic [4:0] month_len(logic leap, logic [3:0] mon);
    logic [4:0] n;
    unique case (mon)
      4'd1:                     n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  n = 5'd30;
      default:                  n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

FILE: src/ecc_datapath.sv
// Datapath of the calendar converter: radix-4 divider, year and month peeling
module ecc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ecc_pkg::BASE_W-1:0]   cfg_wdata,
  input  logic [ecc_pkg::TIME_W-1:0]   in_count,
  input  logic                         in_ms,
  input  ecc_pkg::dp_ctrl_t            ctrl,
  output ecc_pkg::dp_stat_t            stat,
  output logic [7:0]                   years_elapsed,
  output logic [3:0]                   month_index,
  output logic [4:0]                   day_of_month,
  output logic [4:0]                   hour_of_day,
  output logic [5:0]                   minute_of_hour,
  output logic [5:0]                   second_of_minute,
  output logic [9:0]                   millisecond_part
);
  import ecc_pkg::*;

  logic [BASE_W-1:0]  base_year;
  logic [TIME_W-1:0]  num;
  logic [REM_W-1:0]   rem;
  logic [9:0]         msec;
  logic [5:0]         sec;
  logic [5:0]         min;
  logic [4:0]         hour;
  logic [DAYS_W-1:0]  days;
  logic [7:0]         year;
  logic [3:0]         mon;
  logic [BASE_W-1:0]  ymod;

  div_k_t             k;
  logic [1:0]         digit;
  logic [DIGIT_W-1:0] trial;
  logic [DIGIT_W-1:0] diff;
  logic [1:0]         q;
  logic [REM_W-1:0]   rem_next;
  logic [TIME_W-1:0]  num_next;
  logic               leap;
  logic               year_go;
  logic               month_go;
  logic [4:0]         mlen;

  always_comb begin
    k     = div_consts(ctrl.div);
    digit = ctrl.wide ? num[TIME_W-1 -: 2] : num[SEC_W-1 -: 2];
    trial = {rem, digit};
    priority if (trial >= k.d3) begin
      q = 2'd3;  diff = trial - k.d3;
    end else if (trial >= k.d2) begin
      q = 2'd2;  diff = trial - k.d2;
    end else if (trial >= k.d1) begin
      q = 2'd1;  diff = trial - k.d1;
    end else begin
      q = 2'd0;  diff = trial;
    end
    rem_next = diff[REM_W-1:0];
    num_next = {num[TIME_W-3:0], q};
    if (!ctrl.wide || ctrl.last) begin
      num_next[TIME_W-1:SEC_W] = '0;
    end
  end

  always_comb begin
    leap = (ymod == '0) ||
           ((ymod[1:0] == 2'b00) && (ymod != 12'd100) && (ymod != 12'd200) &&
            (ymod != 12'd300));
    year_go  = (days >= DAYS_YEAR) && (!leap || (days >= DAYS_LEAP));
    mlen     = month_len(leap, mon);
    month_go = (mon < MONTHS) && (days >= {11'd0, mlen});
    stat.year_end  = !year_go;
    stat.month_end = !month_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_year <= BASE_YEAR_RESET;
    end else if (cfg_we) begin
      base_year <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (ctrl.accept) begin
          num  <= in_ms ? in_count : {{(TIME_W-SEC_W){1'b0}}, in_count[SEC_W-1:0]};
          rem  <= '0;
          msec <= '0;
          year <= '0;
          mon  <= '0;
          ymod <= base_year;
        end
      end
      OP_DIV: begin
        num <= num_next;
        rem <= ctrl.last ? '0 : rem_next;
        if (ymod >= YEAR_CYCLE) begin
          ymod <= ymod - YEAR_CYCLE;
        end
        if (ctrl.last) begin
          unique case (ctrl.dst)
            DST_MSEC: msec <= rem_next;
            DST_SEC:  sec  <= rem_next[5:0];
            DST_MIN:  min  <= rem_next[5:0];
            DST_HOUR: begin
              hour <= rem_next[4:0];
              days <= num_next[DAYS_W-1:0];
            end
            default: ;
          endcase
        end
      end
      OP_YEAR: begin
        if (year_go) begin
          year <= year + 8'd1;
          days <= days - (leap ? DAYS_LEAP : DAYS_YEAR);
          ymod <= (ymod == YEAR_CYCLE_LAST) ? '0 : ymod + 12'd1;
        end
      end
      OP_MONTH: begin
        if (month_go) begin
          days <= days - {11'd0, mlen};
          mon  <= mon + 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign years_elapsed    = year;
  assign month_index      = mon;
  assign day_of_month     = days[4:0] + 5'd1;
  assign hour_of_day      = hour;
  assign minute_of_hour   = min;
  assign second_of_minute = sec;
  assign millisecond_part = msec;

endmodule

FILE: src/epoch_count_to_calendar_core.sv
// Top level of the epoch count to calendar converter: microsequencer and result register
//
// Converts an elapsed count since the epoch into years elapsed, month, day, hour,
// minute, second and millisecond.
// Input stream s_axis: tdata carries the 42-bit count, tuser is 1 for a count in
// milliseconds and 0 for seconds. One item is taken at a time; tready is high
// only while the sequencer waits at its first step.
// Output stream m_axis: one result per item, held in an output register until
// taken. A stalled receiver holds the result and the sequencer waits at its last
// step; the next item is then accepted once the result has moved on.
// Steps from accept to result valid: millisecond split (radix-4 divider,
// millisecond items only), three radix-4 divides for second, minute and hour,
// then whole years, whole months and the emit step; the year loop takes longest.
// The next item can be taken in the cycle after the result is loaded, never while
// one is in work. Configuration: cfg_we writes cfg_wdata into the base year.
// The user must write it only while idle; the block itself does not enforce this.
// Reset: the sequencer returns to wait, the output is emptied and the base year
// becomes 1970.
module epoch_count_to_calendar_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ecc_pkg::BASE_W-1:0]      cfg_wdata,     // epoch_base_year
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ecc_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // time_count
  input  logic                            s_axis_tuser,  // count_in_milliseconds
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // years elapsed, month_index, day_of_month, hour_of_day, minute_of_hour,
  // second_of_minute, millisecond_part
  output logic [ecc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import ecc_pkg::*;

  upc_t                  upc;
  upc_t                  upc_next;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  uword_t                uw;
  logic                  accept;
  logic                  last;
  logic                  advance;
  logic                  take_jump;
  logic                  out_free;
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  dp_ctrl_t              ctrl;
  dp_stat_t              stat;

  logic [7:0] years_elapsed;
  logic [3:0] month_index;
  logic [4:0] day_of_month;
  logic [4:0] hour_of_day;
  logic [5:0] minute_of_hour;
  logic [5:0] second_of_minute;
  logic [9:0] millisecond_part;

  assign uw            = ucode(upc);
  assign s_axis_tready = (upc == UPC_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last          = (cnt == uw.iters - 5'd1);
  assign out_free      = !out_valid || m_axis_tready;

  always_comb begin
    take_jump = 1'b0;
    unique case (uw.cond)
      COND_ACCEPT: begin
        advance   = accept;
        take_jump = s_axis_tuser;
      end
      COND_COUNT:     advance = last;
      COND_YEAR_END:  advance = stat.year_end;
      COND_MONTH_END: advance = stat.month_end;
      COND_OUT_FREE:  advance = out_free;
      default:        advance = 1'b0;
    endcase
    upc_next = advance ? (take_jump ? uw.jump : uw.next) : upc;
    cnt_next = ((uw.cond == COND_COUNT) && !last) ? cnt + 5'd1 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_IDLE;
      cnt <= '0;
    end else begin
      upc <= upc_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    ctrl.op     = uw.op;
    ctrl.div    = uw.div;
    ctrl.wide   = uw.wide;
    ctrl.dst    = uw.dst;
    ctrl.last   = last;
    ctrl.accept = accept;
  end

  ecc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_count         (s_axis_tdata[TIME_W-1:0]),
    .in_ms            (s_axis_tuser),
    .ctrl             (ctrl),
    .stat             (stat),
    .years_elapsed    (years_elapsed),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .millisecond_part (millisecond_part)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((uw.op == OP_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uw.op == OP_EMIT) && out_free) begin
      out_data <= {4'd0, millisecond_part, second_of_minute, minute_of_hour, hour_of_day,
                   day_of_month, month_index, years_elapsed};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

FILE: src/ecc_checker.sv
// Port-level checker for the epoch count to calendar core, with its bind
`include "epoch_count_to_calendar_core_macros.svh"

module ecc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ecc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  `ECC_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed or dropped")
  `ECC_ASSERT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second item taken while one is in work")
  `ECC_ASSERT(a_field_range, m_axis_tvalid |-> ((m_axis_tdata[11:8] <= 4'd11) && (m_axis_tdata[16:12] != 5'd0) && (m_axis_tdata[21:17] <= 5'd23) && (m_axis_tdata[27:22] <= 6'd59) && (m_axis_tdata[33:28] <= 6'd59) && (m_axis_tdata[43:34] <= 10'd999)), "result field out of range")
  `ECC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind epoch_count_to_calendar_core ecc_checker u_ecc_checker (.*);
